// ===== sv/cke_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the canonical k-mer extractor.
package cke_pkg;

   // Base codes as they arrive on the input stream.
   localparam logic [2:0] DNAA = 3'd0;
   localparam logic [2:0] DNAC = 3'd1;
   localparam logic [2:0] DNAG = 3'd2;
   localparam logic [2:0] DNAT = 3'd3;
   localparam logic [2:0] NDNA = 3'd4;

   localparam int unsigned BASE_BITS = 2;
   localparam int unsigned KMAX      = 32;
   localparam int unsigned KMER_W    = KMAX * BASE_BITS;
   localparam int unsigned K_W       = 6;
   localparam int unsigned RUN_W     = 6;
   localparam int unsigned POS_W     = 16;

   localparam logic [K_W-1:0]   KMER_LEN_RESET = 6'd21;
   localparam logic [K_W-1:0]   K_MAX_CODE     = 6'd32;
   localparam logic [RUN_W-1:0] RUN_MAX        = 6'd32;

   // Control shared by every cell of the row.
   typedef struct packed {
      logic                 fire;
      logic                 start;
      logic [BASE_BITS-1:0] base;
      logic [BASE_BITS-1:0] comp;
   } cke_row_ctl_type;

   // Control that differs from cell to cell.
   typedef struct packed {
      logic in_range;
      logic fwd_entry;
      logic rev_entry;
   } cke_lane_ctl_type;

   typedef struct packed {
      logic              kmer_valid;
      logic [KMER_W-1:0] canonical_kmer;
      logic              from_reverse;
      logic [POS_W-1:0]  base_position;
   } cke_result_type;

endpackage

// ===== sv/cke_cell.sv =====
`timescale 1ns / 1ps
// One base slot of the forward and reverse complement k-mer shift row.
module cke_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  cke_pkg::cke_row_ctl_type         row_ctl,
   input  cke_pkg::cke_lane_ctl_type        lane_ctl,
   input  logic [cke_pkg::BASE_BITS-1:0]    fwd_left,
   input  logic [cke_pkg::BASE_BITS-1:0]    rev_right,
   output logic [cke_pkg::BASE_BITS-1:0]    fwd_q,
   output logic [cke_pkg::BASE_BITS-1:0]    rev_q,
   output logic [cke_pkg::BASE_BITS-1:0]    fwd_nxt,
   output logic [cke_pkg::BASE_BITS-1:0]    rev_nxt
);

   logic [cke_pkg::BASE_BITS-1:0] fwd_ff, fwd_in;
   logic [cke_pkg::BASE_BITS-1:0] rev_ff, rev_in;
   logic [cke_pkg::BASE_BITS-1:0] fwd_shift, rev_shift;

   // A new read discards what the neighbors hold before the base shifts in.
   always_comb begin
      fwd_shift = row_ctl.start ? '0 : fwd_left;
      rev_shift = row_ctl.start ? '0 : rev_right;
      if (lane_ctl.fwd_entry) begin
         fwd_shift = fwd_shift | row_ctl.base;
      end
      if (lane_ctl.rev_entry) begin
         rev_shift = rev_shift | row_ctl.comp;
      end
      fwd_in = lane_ctl.in_range ? fwd_shift : '0;
      rev_in = lane_ctl.in_range ? rev_shift : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         rev_ff <= '0;
      end else if (row_ctl.fire) begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
      end
   end

   assign fwd_q   = fwd_ff;
   assign rev_q   = rev_ff;
   assign fwd_nxt = fwd_in;
   assign rev_nxt = rev_in;

endmodule

// ===== sv/cke_out_skid.sv =====
`timescale 1ns / 1ps
// Output register with one skid entry for the result stream.
module cke_out_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cke_pkg::cke_result_type in_result,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cke_pkg::cke_result_type out_result
);

   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   cke_pkg::cke_result_type out_data_ff, out_data_in;
   cke_pkg::cke_result_type skid_data_ff, skid_data_in;
   logic                    in_fire, out_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_fire = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_fire) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_fire) begin
            out_data_in = in_result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!out_valid_ff) begin
            out_data_in  = in_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_data_ff;

   // The skid entry is only ever filled behind a held output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

endmodule

// ===== sv/canonical_kmer_extractor.sv =====
`timescale 1ns / 1ps
// Canonical k-mer extractor: one base per transfer in, one k-mer result per transfer out.
//
// The block takes one nucleotide per input transfer and returns one result transfer for
// each, in order. While the consumer keeps up it sustains one base per clock cycle: the
// forward and reverse complement k-mers live in a row of 32 cells of two bits each, and
// every accepted base shifts the whole row by one slot. The result of a base is registered
// in an output register on the rsp side; that register plus one skid entry let the block
// take one more base into the skid entry while the consumer stalls, after which req_tready
// drops until the consumer drains. A base flagged as the start of a read clears both
// strands, the clean-base run and the position counter before it is taken. Unknown bases
// (codes four through seven) shift in zero and hold kmer_valid low until k clean bases
// follow. When kmer_valid is low the canonical k-mer and the strand flag read as zero,
// while the base position is still reported. Ties go to forward. The user must write
// k through csr_wr_en / csr_wr_data only while the stream is idle; the block does not
// check. Zero reads as one, above 32 as 32. Positions cap at min(MAX_READ_LEN - 1, 65535).
module canonical_kmer_extractor #(
   parameter int unsigned MAX_READ_LEN = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: k, the number of bases per k-mer.
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] base_code, [7:3] zero
   input  logic [0:0]  req_tuser,   // [0] read_start
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [63:0] canonical_kmer, [79:64] base_position
   output logic [1:0]  rsp_tuser    // [0] kmer_valid, [1] from_reverse
);

   localparam int unsigned KMAX   = cke_pkg::KMAX;
   localparam int unsigned BASE_W = cke_pkg::BASE_BITS;
   localparam int unsigned KMER_W = cke_pkg::KMER_W;
   localparam int unsigned POS_W  = cke_pkg::POS_W;
   localparam logic [POS_W-1:0] POS_CAP =
      (MAX_READ_LEN - 1 < 65535) ? POS_W'(MAX_READ_LEN - 1) : {POS_W{1'b1}};

   // Configuration register.
   logic [cke_pkg::K_W-1:0] kmer_length_ff;
   logic [cke_pkg::K_W-1:0] k_eff;
   logic [cke_pkg::K_W-1:0] k_top;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= cke_pkg::KMER_LEN_RESET;
      end else if (csr_wr_en) begin
         kmer_length_ff <= csr_wr_data;
      end
   end

   // A zero k behaves as one and anything above the row length as a full row.
   always_comb begin
      if (kmer_length_ff == '0) begin
         k_eff = cke_pkg::K_W'(1);
      end else if (kmer_length_ff > cke_pkg::K_MAX_CODE) begin
         k_eff = cke_pkg::K_MAX_CODE;
      end else begin
         k_eff = kmer_length_ff;
      end
      k_top = k_eff - cke_pkg::K_W'(1);
   end

   // Input decode.
   logic       in_fire;
   logic       start;
   logic       base_ok;
   logic [2:0] base_code;
   logic       skid_ready;

   assign base_code  = req_tdata[2:0];
   assign start      = req_tuser[0];
   assign base_ok    = (base_code <= cke_pkg::DNAT);
   assign req_tready = skid_ready;
   assign in_fire    = req_tvalid && req_tready;

   cke_pkg::cke_row_ctl_type row_ctl;

   always_comb begin
      row_ctl.fire  = in_fire;
      row_ctl.start = start;
      row_ctl.base  = base_code[BASE_W-1:0];
      row_ctl.comp  = cke_pkg::DNAT[BASE_W-1:0] - base_code[BASE_W-1:0];
   end

   // The cell row. Forward bases move toward higher slots; the reverse complement moves
   // toward slot zero and takes each new complement base in slot k-1.
   logic [KMAX-1:0][BASE_W-1:0] fwd_q, rev_q, fwd_nxt, rev_nxt;

   for (genvar i = 0; i < KMAX; i++) begin : g_cell
      cke_pkg::cke_lane_ctl_type   lane_ctl;
      logic [BASE_W-1:0]           fwd_left;
      logic [BASE_W-1:0]           rev_right;

      assign lane_ctl.in_range  = (cke_pkg::K_W'(i) < k_eff);
      assign lane_ctl.fwd_entry = (i == 0) && base_ok;
      assign lane_ctl.rev_entry = (cke_pkg::K_W'(i) == k_top) && base_ok;

      if (i == 0) begin : g_low
         assign fwd_left = '0;
      end else begin : g_mid
         assign fwd_left = fwd_q[i-1];
      end
      if (i == KMAX - 1) begin : g_high
         assign rev_right = '0;
      end else begin : g_below
         assign rev_right = rev_q[i+1];
      end

      cke_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .row_ctl   (row_ctl),
         .lane_ctl  (lane_ctl),
         .fwd_left  (fwd_left),
         .rev_right (rev_right),
         .fwd_q     (fwd_q[i]),
         .rev_q     (rev_q[i]),
         .fwd_nxt   (fwd_nxt[i]),
         .rev_nxt   (rev_nxt[i])
      );
   end

   // Clean-base run and read position.
   logic [cke_pkg::RUN_W-1:0] clean_run_ff, clean_run_in, run_base;
   logic [POS_W-1:0]          position_count_ff, position_count_in, pos_base;

   always_comb begin
      run_base = start ? '0 : clean_run_ff;
      pos_base = start ? '0 : position_count_ff;
      if (!base_ok) begin
         clean_run_in = '0;
      end else if (run_base >= cke_pkg::RUN_MAX) begin
         clean_run_in = run_base;
      end else begin
         clean_run_in = run_base + cke_pkg::RUN_W'(1);
      end
      position_count_in = (pos_base < POS_CAP) ? pos_base + POS_W'(1) : pos_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_run_ff      <= '0;
         position_count_ff <= '0;
      end else if (in_fire) begin
         clean_run_ff      <= clean_run_in;
         position_count_ff <= position_count_in;
      end
   end

   // Strand selection on the updated row: the smaller value wins, forward on a tie.
   logic [KMER_W-1:0]       fwd_kmer, rev_kmer;
   logic                    kmer_ok;
   logic                    rev_smaller;
   cke_pkg::cke_result_type result;

   assign fwd_kmer    = fwd_nxt;
   assign rev_kmer    = rev_nxt;
   assign kmer_ok     = (clean_run_in >= k_eff);
   assign rev_smaller = (rev_kmer < fwd_kmer);

   always_comb begin
      result.kmer_valid    = kmer_ok;
      result.from_reverse  = kmer_ok && rev_smaller;
      result.base_position = pos_base;
      if (!kmer_ok) begin
         result.canonical_kmer = '0;
      end else if (rev_smaller) begin
         result.canonical_kmer = rev_kmer;
      end else begin
         result.canonical_kmer = fwd_kmer;
      end
   end

   cke_pkg::cke_result_type rsp_result;

   cke_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (skid_ready),
      .in_result  (result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.base_position, rsp_result.canonical_kmer};
   assign rsp_tuser = {rsp_result.from_reverse, rsp_result.kmer_valid};

   // A base that opens a read always leaves the counter pointing at the second base.
   a_read_start_pos: assert property (@(posedge clock) disable iff (reset)
      in_fire && start |=> position_count_ff == POS_W'(1))
      else $error("position counter did not restart on a new read");

   // The clean-base run saturates at the row length.
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      clean_run_ff <= cke_pkg::RUN_MAX)
      else $error("clean-base run exceeded the row length");

   // A result without a full clean k-mer carries no k-mer and no strand flag.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_result.kmer_valid |->
         rsp_result.canonical_kmer == '0 && !rsp_result.from_reverse)
      else $error("invalid result carries a k-mer value or strand flag");

endmodule
